>>> rtl/core/vector_normalize_3d_unit_macros.svh
// Assertion macros used by the checker of the vector normalize unit.
// No dependencies; take in by `include before use.
`ifndef VECTOR_NORMALIZE_3D_UNIT_MACROS_SVH
`define VECTOR_NORMALIZE_3D_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VN3D_ASSERT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("vn3d assertion failed");

// Next-cycle implication, disabled during reset.
`define VN3D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("vn3d assertion failed");

`endif

>>> rtl/core/vn3d_pkg.sv
// Package for the 3D vector normalize unit: widths and reset constants.
// No dependencies.
package vn3d_pkg;
  localparam int unsigned InWidth       = 32;
  localparam int unsigned OutFracBits   = 30;
  localparam int unsigned MinMagWidth   = 32;
  localparam logic [MinMagWidth-1:0] MinMagReset = MinMagWidth'(1);
endpackage

>>> rtl/core/vector_normalize_3d_unit.sv
// Normalizes one signed Q16.16 vector per cycle into a signed Q2.30 unit vector plus its
// unsigned length (floor of the root of the exact squared sum). Fully pipelined: one beat
// in and one beat out per cycle, through the bit-per-stage square root (IN_WIDTH stages)
// and the bit-per-stage dividers (OUT_FRAC_BITS + 1 stages). A length below min_magnitude,
// or zero, gives the zero vector with tuser set. The whole pipe holds while the output beat
// waits.
// Depends on vn3d_pkg.
module vector_normalize_3d_unit #(
  parameter int unsigned IN_WIDTH      = vn3d_pkg::InWidth,
  parameter int unsigned OUT_FRAC_BITS = vn3d_pkg::OutFracBits,
  localparam int unsigned InDw  = ((3 * IN_WIDTH + 7) / 8) * 8,
  localparam int unsigned UW    = OUT_FRAC_BITS + 2,
  localparam int unsigned OutDw = ((3 * UW + IN_WIDTH + 7) / 8) * 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [vn3d_pkg::MinMagWidth-1:0]   cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [InDw-1:0]                    s_axis_tdata,  // x_in, y_in, z_in
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [OutDw-1:0]                   m_axis_tdata,  // x_unit, y_unit, z_unit, magnitude
  output logic                               m_axis_tuser   // degenerate
);
  localparam int unsigned W  = IN_WIDTH;
  localparam int unsigned F  = OUT_FRAC_BITS;
  localparam int unsigned MW = vn3d_pkg::MinMagWidth;
  localparam int unsigned CW = (W > MW) ? W : MW;

  typedef struct packed {
    logic [2:0]        neg;
    logic [2:0][W-1:0] size;
  } carry_t;

  logic          en;
  logic [MW-1:0] min_mag_q;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_mag_q <= vn3d_pkg::MinMagReset;
    end else if (cfg_we_i) begin
      min_mag_q <= cfg_wdata_i;
    end
  end

  // Stage A: absolute values
  logic   a_v_q;
  carry_t a_c_q;
  // Stage B: squares
  logic              b_v_q;
  carry_t            b_c_q;
  logic [2:0][2*W-1:0] b_sq_q;
  // Stage C: squared sum
  logic           c_v_q;
  carry_t         c_c_q;
  logic [2*W-1:0] c_sum_q;

  logic [2:0][W-1:0] in_comp;
  assign in_comp[0] = s_axis_tdata[W-1:0];
  assign in_comp[1] = s_axis_tdata[2*W-1:W];
  assign in_comp[2] = s_axis_tdata[3*W-1:2*W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= s_axis_tvalid;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        a_c_q.neg[k]  <= in_comp[k][W-1];
        a_c_q.size[k] <= in_comp[k][W-1] ? (W'(0) - in_comp[k]) : in_comp[k];
        b_sq_q[k]     <= (2*W)'(a_c_q.size[k]) * (2*W)'(a_c_q.size[k]);
      end
      b_c_q   <= a_c_q;
      c_c_q   <= b_c_q;
      c_sum_q <= b_sq_q[0] + b_sq_q[1] + b_sq_q[2];
    end
  end

  // Square root: one root bit per stage
  logic           sq_v_q    [W];
  carry_t         sq_c_q    [W];
  logic [W+1:0]   sq_rem_q  [W];
  logic [W-1:0]   sq_root_q [W];
  logic [2*W-1:0] sq_s_q    [W];

  for (genvar k = 0; k < W; k++) begin : g_sqrt
    logic           v_in;
    carry_t         c_in;
    logic [W+1:0]   rem_in;
    logic [W-1:0]   root_in;
    logic [2*W-1:0] s_in;
    logic [W+1:0]   rem2;
    logic [W+1:0]   trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign v_in    = c_v_q;
      assign c_in    = c_c_q;
      assign rem_in  = '0;
      assign root_in = '0;
      assign s_in    = c_sum_q;
    end else begin : g_next
      assign v_in    = sq_v_q[k-1];
      assign c_in    = sq_c_q[k-1];
      assign rem_in  = sq_rem_q[k-1];
      assign root_in = sq_root_q[k-1];
      assign s_in    = sq_s_q[k-1];
    end

    assign rem2  = {rem_in[W-1:0], s_in[2*W-1:2*W-2]};
    assign trial = {root_in, 2'b01};
    assign ge    = rem2 >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k] <= 1'b0;
      end else if (en) begin
        sq_v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_c_q[k]    <= c_in;
        sq_rem_q[k]  <= ge ? (rem2 - trial) : rem2;
        sq_root_q[k] <= {root_in[W-2:0], ge};
        sq_s_q[k]    <= {s_in[2*W-3:0], 2'b00};
      end
    end
  end

  // Division: one quotient bit per stage, three lanes
  logic              dv_v_q   [F+1];
  logic [2:0]        dv_neg_q [F+1];
  logic              dv_deg_q [F+1];
  logic [W-1:0]      dv_mag_q [F+1];
  logic [2:0][W-1:0] dv_r_q   [F+1];
  logic [2:0][F:0]   dv_qt_q  [F+1];

  logic [W-1:0] root_fin;
  logic         deg_fin;
  assign root_fin = sq_root_q[W-1];
  assign deg_fin  = (root_fin == '0) || (CW'(root_fin) < CW'(min_mag_q));

  for (genvar j = 0; j <= F; j++) begin : g_div
    logic              v_in;
    logic [2:0]        neg_in;
    logic              deg_in;
    logic [W-1:0]      mag_in;
    logic [2:0][W:0]   r_in;
    logic [2:0][F:0]   qt_in;
    logic [2:0][W:0]   r_sub;
    logic [2:0]        ge;

    if (j == 0) begin : g_first
      assign v_in   = sq_v_q[W-1];
      assign neg_in = sq_c_q[W-1].neg;
      assign deg_in = deg_fin;
      assign mag_in = root_fin;
      for (genvar k = 0; k < 3; k++) begin : g_lane
        assign r_in[k]  = {1'b0, sq_c_q[W-1].size[k]};
        assign qt_in[k] = '0;
      end
    end else begin : g_next
      assign v_in   = dv_v_q[j-1];
      assign neg_in = dv_neg_q[j-1];
      assign deg_in = dv_deg_q[j-1];
      assign mag_in = dv_mag_q[j-1];
      for (genvar k = 0; k < 3; k++) begin : g_lane
        assign r_in[k]  = {dv_r_q[j-1][k], 1'b0};
        assign qt_in[k] = dv_qt_q[j-1][k];
      end
    end

    for (genvar k = 0; k < 3; k++) begin : g_cmp
      assign ge[k]    = r_in[k] >= {1'b0, mag_in};
      assign r_sub[k] = ge[k] ? (r_in[k] - {1'b0, mag_in}) : r_in[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j] <= 1'b0;
      end else if (en) begin
        dv_v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_neg_q[j] <= neg_in;
        dv_deg_q[j] <= deg_in;
        dv_mag_q[j] <= mag_in;
        for (int k = 0; k < 3; k++) begin
          // remainder stays below the length, so the top bit drops
          dv_r_q[j][k]  <= r_sub[k][W-1:0];
          dv_qt_q[j][k] <= {qt_in[k][F-1:0], ge[k]};
        end
      end
    end
  end

  // Output register: apply sign, zero degenerate results
  logic [2:0][UW-1:0] unit_d;
  logic [2:0][UW-1:0] unit_q;
  logic [W-1:0]       mag_q;
  logic               deg_q;
  logic               out_v_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dv_deg_q[F]) begin
        unit_d[k] = '0;
      end else if (dv_neg_q[F][k]) begin
        unit_d[k] = UW'(0) - {1'b0, dv_qt_q[F][k]};
      end else begin
        unit_d[k] = {1'b0, dv_qt_q[F][k]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v_q[F];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      unit_q <= unit_d;
      mag_q  <= dv_mag_q[F];
      deg_q  <= dv_deg_q[F];
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OutDw'({mag_q, unit_q[2], unit_q[1], unit_q[0]});
  assign m_axis_tuser  = deg_q;
endmodule

>>> rtl/core/vn3d_checker.sv
// Port-level checker for vector_normalize_3d_unit, bound into vector_normalize_3d_unit.
// Depends on vn3d_pkg and vector_normalize_3d_unit_macros.svh.
`include "vector_normalize_3d_unit_macros.svh"

module vn3d_checker #(
  parameter int unsigned IN_WIDTH      = vn3d_pkg::InWidth,
  parameter int unsigned OUT_FRAC_BITS = vn3d_pkg::OutFracBits,
  localparam int unsigned UW    = OUT_FRAC_BITS + 2,
  localparam int unsigned OutDw = ((3 * UW + IN_WIDTH + 7) / 8) * 8
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OutDw-1:0] m_axis_tdata,
  input logic             m_axis_tuser
);
  logic units_zero;
  assign units_zero = (m_axis_tdata[3*UW-1:0] == '0);

  // stalled output beat holds
  `VN3D_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  // degenerate beat carries the zero vector
  `VN3D_ASSERT(a_deg_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, units_zero)
  // input side never blocks while the output drains
  `VN3D_ASSERT(a_ready_flow, clk_i, rst_ni, m_axis_tready || !m_axis_tvalid, s_axis_tready)
endmodule

bind vector_normalize_3d_unit vn3d_checker #(
  .IN_WIDTH      (IN_WIDTH),
  .OUT_FRAC_BITS (OUT_FRAC_BITS)
) u_vn3d_checker (.*);
